// ----- rtl/snm_pkg.sv -----
// shared types and constants of the sensor min/max normalizer
package snm_pkg;

	localparam int CHANNELS      = 6;
	localparam int NORM_BITS     = 16;
	localparam int AVG_BITS      = 8;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [0:0] CFG_AVG_COUNT  = 1'b0;
	localparam logic [0:0] CFG_FULL_SCALE = 1'b1;

	localparam logic [AVG_BITS-1:0]  AVG_COUNT_RESET  = 8'd4;
	localparam logic [NORM_BITS-1:0] FULL_SCALE_RESET = 16'd1000;

	typedef enum logic [1:0] {
		OP_RESTART = 2'd0,
		OP_UPDATE  = 2'd1,
		OP_MEASURE = 2'd2,
		OP_IGNORE  = 2'd3
	} snm_op_t;

	typedef logic [NORM_BITS-1:0] norm_t;

	typedef struct packed {
		logic                restart;
		logic                update;
		logic                accum;
		logic                start;
		logic [AVG_BITS-1:0] count;
	} snm_lane_ctl_t;

endpackage

// ----- rtl/snm_in_if.sv -----
// scan input channel: opcode and six samples
interface snm_in_if #(
	parameter int SAMPLE_BITS = 12
);
	logic                   valid;
	logic                   ready;
	snm_pkg::snm_op_t       opcode;
	logic [SAMPLE_BITS-1:0] sample0;
	logic [SAMPLE_BITS-1:0] sample1;
	logic [SAMPLE_BITS-1:0] sample2;
	logic [SAMPLE_BITS-1:0] sample3;
	logic [SAMPLE_BITS-1:0] sample4;
	logic [SAMPLE_BITS-1:0] sample5;

	modport source (
		output valid, opcode, sample0, sample1, sample2, sample3, sample4, sample5,
		input  ready
	);
	modport sink (
		input  valid, opcode, sample0, sample1, sample2, sample3, sample4, sample5,
		output ready
	);
endinterface

// ----- rtl/snm_out_if.sv -----
// result channel: six normalized values
interface snm_out_if;
	logic              valid;
	logic              ready;
	snm_pkg::norm_t    norm0;
	snm_pkg::norm_t    norm1;
	snm_pkg::norm_t    norm2;
	snm_pkg::norm_t    norm3;
	snm_pkg::norm_t    norm4;
	snm_pkg::norm_t    norm5;

	modport source (
		output valid, norm0, norm1, norm2, norm3, norm4, norm5,
		input  ready
	);
	modport sink (
		input  valid, norm0, norm1, norm2, norm3, norm4, norm5,
		output ready
	);
endinterface

// ----- rtl/snm_div.sv -----
// iterative restoring divider, one quotient bit per cycle
module snm_div #(
	parameter int NUM_BITS = 28,
	parameter int DEN_BITS = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_BITS-1:0] num,
	input  logic [DEN_BITS-1:0] den,
	output logic [NUM_BITS-1:0] quo,
	output logic                done
);
	localparam int CNT_BITS = $clog2(NUM_BITS + 1);

	logic [CNT_BITS-1:0] cnt_q;
	logic                done_q;
	logic [DEN_BITS-1:0] rem_q;
	logic [DEN_BITS-1:0] den_q;
	logic [NUM_BITS-1:0] quo_q;

	logic [DEN_BITS:0]   shifted;
	logic [DEN_BITS:0]   trial;
	logic                fits;

	assign shifted = {rem_q, quo_q[NUM_BITS-1]};
	assign trial   = shifted - {1'b0, den_q};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_BITS'(NUM_BITS);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - CNT_BITS'(1);
				done_q <= (cnt_q == CNT_BITS'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? trial[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];
			quo_q <= {quo_q[NUM_BITS-2:0], fits};
		end
	end

	assign quo  = quo_q;
	assign done = done_q;
endmodule

// ----- rtl/snm_lane.sv -----
// one channel lane: min/max/sum storage, averaging and normalizing sequence
module snm_lane #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  snm_pkg::snm_lane_ctl_t        ctl,
	input  logic [SAMPLE_BITS-1:0]        sample,
	input  logic [snm_pkg::NORM_BITS-1:0] full_scale,
	output snm_pkg::norm_t                norm,
	output logic                          done
);
	localparam int SUM_BITS  = SAMPLE_BITS + snm_pkg::AVG_BITS;
	localparam int PROD_BITS = SAMPLE_BITS + snm_pkg::NORM_BITS;

	typedef enum logic [2:0] {
		L_IDLE,
		L_AVG,
		L_MUL,
		L_LOAD,
		L_NORM
	} lane_state_t;

	lane_state_t            state_q;
	logic                   done_q;
	snm_pkg::norm_t         norm_q;
	logic [SAMPLE_BITS-1:0] min_q;
	logic [SAMPLE_BITS-1:0] max_q;
	logic [SUM_BITS-1:0]    sum_q;
	logic [SAMPLE_BITS-1:0] diff_q;
	logic [PROD_BITS-1:0]   prod_q;

	logic [SUM_BITS-1:0]    sum_next;
	logic                   div_start;
	logic [PROD_BITS-1:0]   div_num;
	logic [SAMPLE_BITS-1:0] div_den;
	logic [PROD_BITS-1:0]   div_quo;
	logic                   div_done;
	logic [SUM_BITS-1:0]    avg;
	logic [SAMPLE_BITS-1:0] clamped;

	assign sum_next = sum_q + SUM_BITS'(sample);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
			max_q <= '0;
			sum_q <= '0;
		end else if (ctl.restart) begin
			min_q <= sample;
			max_q <= sample;
			sum_q <= '0;
		end else if (ctl.update) begin
			if (sample > max_q) begin
				max_q <= sample;
			end
			if (sample < min_q) begin
				min_q <= sample;
			end
			sum_q <= '0;
		end else if (ctl.accum) begin
			sum_q <= ctl.start ? '0 : sum_next;
		end
	end

	always_comb begin
		div_start = 1'b0;
		div_num   = PROD_BITS'(sum_next);
		div_den   = SAMPLE_BITS'(ctl.count);
		unique case (state_q)
			L_IDLE: begin
				div_start = ctl.start;
			end
			L_LOAD: begin
				div_start = 1'b1;
				div_num   = prod_q;
				div_den   = max_q - min_q;
			end
			default: begin
			end
		endcase
	end

	snm_div #(
		.NUM_BITS(PROD_BITS),
		.DEN_BITS(SAMPLE_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.quo   (div_quo),
		.done  (div_done)
	);

	// clamp the average into the calibrated range
	assign avg = div_quo[SUM_BITS-1:0];
	always_comb begin
		if (avg > SUM_BITS'(max_q)) begin
			clamped = max_q;
		end else if (avg < SUM_BITS'(min_q)) begin
			clamped = min_q;
		end else begin
			clamped = avg[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			done_q  <= 1'b0;
			norm_q  <= '0;
		end else begin
			unique case (state_q)
				L_IDLE: begin
					if (ctl.start) begin
						state_q <= L_AVG;
						done_q  <= 1'b0;
					end
				end
				L_AVG: begin
					if (div_done) begin
						state_q <= L_MUL;
					end
				end
				L_MUL: begin
					state_q <= L_LOAD;
				end
				L_LOAD: begin
					state_q <= L_NORM;
				end
				L_NORM: begin
					if (div_done) begin
						state_q <= L_IDLE;
						done_q  <= 1'b1;
						norm_q  <= (max_q > min_q) ? div_quo[snm_pkg::NORM_BITS-1:0] : '0;
					end
				end
				default: begin
					state_q <= L_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == L_AVG && div_done) begin
			diff_q <= clamped - min_q;
		end
		if (state_q == L_MUL) begin
			prod_q <= PROD_BITS'(diff_q) * PROD_BITS'(full_scale);
		end
	end

	assign norm = norm_q;
	assign done = done_q;
endmodule

// ----- rtl/sensor_minmax_normalizer.sv -----
// top level of the sensor min/max normalizer: six lanes and the result merge
// Usage: scans enter on in_ch (opcode plus six samples), normalized results
// leave on out_ch (six values), both valid/ready; a beat moves when both are
// high. avg_count and full_scale are written through cfg_we/cfg_idx/cfg_data
// by the user only while the block is idle; the block does not enforce it.
// Restart, update and ignored scans give no result, nor does a measure scan
// that does not complete an average. The measure scan that completes an
// average starts all six lanes at once; each lane runs its shared bit-serial
// divider twice (average, then normalize) with a multiply between, and the
// result beat is loaded once the normalize pass is done in every lane;
// in_ch.ready is low from that scan until then.
// The result sits in an output register; the next scans are taken while it
// waits. If out_ch stalls when a new result is done, the lanes hold it and
// in_ch stays low until the output register is free.
// Reset clears min, max, sums and the scan count, sets avg_count to 4 and
// full_scale to 1000.
module sensor_minmax_normalizer #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	snm_in_if.sink                            in_ch,
	snm_out_if.source                         out_ch,
	input  logic                              cfg_we,
	input  logic [0:0]                        cfg_idx,
	input  logic [snm_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	typedef enum logic {
		S_IDLE,
		S_BUSY
	} top_state_t;

	top_state_t                      state_q;
	logic                            out_valid_q;
	logic [snm_pkg::AVG_BITS-1:0]    avg_count_q;
	logic [snm_pkg::NORM_BITS-1:0]   full_scale_q;
	logic [snm_pkg::AVG_BITS-1:0]    scan_count_q;
	snm_pkg::norm_t                  norm_q [snm_pkg::CHANNELS];

	logic                            accept;
	logic [snm_pkg::AVG_BITS-1:0]    scan_next;
	logic [snm_pkg::AVG_BITS-1:0]    target;
	logic                            emit;
	logic                            load_out;
	logic                            norm_in_range;
	snm_pkg::snm_lane_ctl_t          lane_ctl;
	logic [SAMPLE_BITS-1:0]          samples   [snm_pkg::CHANNELS];
	snm_pkg::norm_t                  lane_norm [snm_pkg::CHANNELS];
	logic [snm_pkg::CHANNELS-1:0]    lane_done;

	assign in_ch.ready = (state_q == S_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;

	assign samples[0] = in_ch.sample0;
	assign samples[1] = in_ch.sample1;
	assign samples[2] = in_ch.sample2;
	assign samples[3] = in_ch.sample3;
	assign samples[4] = in_ch.sample4;
	assign samples[5] = in_ch.sample5;

	assign scan_next = scan_count_q + snm_pkg::AVG_BITS'(1);
	assign target    = (avg_count_q == '0) ? snm_pkg::AVG_BITS'(1) : avg_count_q;
	assign emit      = accept && (in_ch.opcode == snm_pkg::OP_MEASURE) && (scan_next >= target);

	always_comb begin
		lane_ctl.restart = accept && (in_ch.opcode == snm_pkg::OP_RESTART);
		lane_ctl.update  = accept && (in_ch.opcode == snm_pkg::OP_UPDATE);
		lane_ctl.accum   = accept && (in_ch.opcode == snm_pkg::OP_MEASURE);
		lane_ctl.start   = emit;
		lane_ctl.count   = scan_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_count_q  <= snm_pkg::AVG_COUNT_RESET;
			full_scale_q <= snm_pkg::FULL_SCALE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				snm_pkg::CFG_AVG_COUNT:  avg_count_q  <= cfg_data[snm_pkg::AVG_BITS-1:0];
				snm_pkg::CFG_FULL_SCALE: full_scale_q <= cfg_data[snm_pkg::NORM_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_count_q <= '0;
		end else if (lane_ctl.restart || lane_ctl.update) begin
			scan_count_q <= '0;
		end else if (lane_ctl.accum) begin
			scan_count_q <= emit ? '0 : scan_next;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < snm_pkg::CHANNELS; gi++) begin : g_lane
			snm_lane #(
				.SAMPLE_BITS(SAMPLE_BITS)
			) u_lane (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (lane_ctl),
				.sample    (samples[gi]),
				.full_scale(full_scale_q),
				.norm      (lane_norm[gi]),
				.done      (lane_done[gi])
			);
		end
	endgenerate

	// merge: all lanes finish together, the results go out as one beat
	assign load_out = (state_q == S_BUSY) && (&lane_done) && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (emit) begin
						state_q <= S_BUSY;
					end
				end
				S_BUSY: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			norm_q <= lane_norm;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.norm0 = norm_q[0];
	assign out_ch.norm1 = norm_q[1];
	assign out_ch.norm2 = norm_q[2];
	assign out_ch.norm3 = norm_q[3];
	assign out_ch.norm4 = norm_q[4];
	assign out_ch.norm5 = norm_q[5];

	always_comb begin
		norm_in_range = 1'b1;
		for (int i = 0; i < snm_pkg::CHANNELS; i++) begin
			if (norm_q[i] > full_scale_q) begin
				norm_in_range = 1'b0;
			end
		end
	end

	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(&lane_done) || !(|lane_done))
		else $error("lanes finished out of step");

	a_norm_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> norm_in_range)
		else $error("normalized value above full scale");

	a_emit_starts_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (state_q == S_BUSY) && (lane_done == '0) && (scan_count_q == '0))
		else $error("completed average did not start the lanes");
endmodule

// ----- tb/snm_result_checker.sv -----
// checker for the sensor normalizer: tracks calibration and averages, compares result beats
module snm_result_checker
	import snm_pkg::*;
#(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                     clk,
	input  logic                     arst_n,
	snm_in_if                        in_ch,
	snm_out_if                       out_ch,
	input  logic                     cfg_we,
	input  logic [0:0]               cfg_idx,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output int                       mismatches,
	output int                       outstanding
);

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] scan_vec_t;
	typedef logic [CHANNELS-1:0][NORM_BITS-1:0] norm_vec_t;

	sample_t                cal_lo [CHANNELS];
	sample_t                cal_hi [CHANNELS];
	logic [SAMPLE_BITS+7:0] lane_sum [CHANNELS];
	int unsigned            scans_summed;
	logic [AVG_BITS-1:0]    avg_count;
	logic [NORM_BITS-1:0]   full_scale;
	norm_vec_t              expected_norms [$];
	int                     fail_count;

	assign mismatches = fail_count;

	function automatic norm_t scale_lane(sample_t avg, sample_t lo, sample_t hi,
		logic [NORM_BITS-1:0] fs);
		sample_t         c;
		longint unsigned num;
		if (hi <= lo) begin
			return '0;
		end
		c = avg;
		if (c > hi) begin
			c = hi;
		end
		if (c < lo) begin
			c = lo;
		end
		num = 64'(c - lo) * 64'(fs);
		return norm_t'(num / 64'(hi - lo));
	endfunction

	task automatic report(string msg);
		$display("%0t mismatch: %s", $time, msg);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		norm_vec_t   seen;
		norm_vec_t   want;
		scan_vec_t   scan;
		int unsigned target;
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				cal_lo[i]   = '0;
				cal_hi[i]   = '0;
				lane_sum[i] = '0;
			end
			scans_summed = 0;
			avg_count    = AVG_COUNT_RESET;
			full_scale   = FULL_SCALE_RESET;
			fail_count   = 0;
			expected_norms.delete();
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				seen = {out_ch.norm5, out_ch.norm4, out_ch.norm3,
					out_ch.norm2, out_ch.norm1, out_ch.norm0};
				if (expected_norms.size() == 0) begin
					report("result beat with no completed average behind it");
				end else begin
					want = expected_norms.pop_front();
					for (int i = 0; i < CHANNELS; i++) begin
						if (seen[i] !== want[i]) begin
							report($sformatf("norm%0d is %0d, expected %0d",
								i, seen[i], want[i]));
						end
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				scan = {in_ch.sample5, in_ch.sample4, in_ch.sample3,
					in_ch.sample2, in_ch.sample1, in_ch.sample0};
				case (in_ch.opcode)
					OP_RESTART, OP_UPDATE: begin
						for (int i = 0; i < CHANNELS; i++) begin
							if (in_ch.opcode == OP_RESTART) begin
								cal_lo[i] = scan[i];
								cal_hi[i] = scan[i];
							end else begin
								if (scan[i] > cal_hi[i]) begin
									cal_hi[i] = scan[i];
								end
								if (scan[i] < cal_lo[i]) begin
									cal_lo[i] = scan[i];
								end
							end
							lane_sum[i] = '0;
						end
						scans_summed = 0;
					end
					OP_MEASURE: begin
						for (int i = 0; i < CHANNELS; i++) begin
							lane_sum[i] = lane_sum[i] + {8'd0, scan[i]};
						end
						scans_summed++;
						target = (avg_count == '0) ? 1 : int'(avg_count);
						if (scans_summed >= target) begin
							for (int i = 0; i < CHANNELS; i++) begin
								want[i] = scale_lane(sample_t'(lane_sum[i] / scans_summed),
									cal_lo[i], cal_hi[i], full_scale);
								lane_sum[i] = '0;
							end
							expected_norms.push_back(want);
							scans_summed = 0;
						end
					end
					default: begin
					end
				endcase
			end
			if (cfg_we) begin
				if (cfg_idx == CFG_AVG_COUNT) begin
					avg_count = cfg_data[AVG_BITS-1:0];
				end else begin
					full_scale = cfg_data[NORM_BITS-1:0];
				end
			end
		end
		outstanding <= expected_norms.size();
	end

endmodule

// ----- tb/tb_sensor_minmax_normalizer.sv -----
// testbench top for the sensor normalizer: clock, reset, scan and config stimulus, verdict
module tb_sensor_minmax_normalizer;
	import snm_pkg::*;

	localparam int SAMPLE_BITS  = 12;
	localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
	localparam int LATENCY      = 2 * (SAMPLE_BITS + 16) + 5;
	localparam int SETTLE       = LATENCY + 16;
	localparam int RANDOM_SCANS = 2000;
	localparam int HOLD_CYCLES  = 1500;
	localparam int LIMIT        = 1500000;

	typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] sample_vec_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_we;
	logic [0:0]               cfg_idx;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	int                       mismatches;
	int                       outstanding;
	int                       send_idle_pct;
	int                       recv_stall_pct;
	int                       hold_reqs;
	int                       scans_sent;

	snm_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
	snm_out_if out_ch ();

	sensor_minmax_normalizer #(.SAMPLE_BITS(SAMPLE_BITS)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	snm_result_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	function automatic sample_vec_t mk(int a0, int a1, int a2, int a3, int a4, int a5);
		return {SAMPLE_BITS'(a5), SAMPLE_BITS'(a4), SAMPLE_BITS'(a3),
			SAMPLE_BITS'(a2), SAMPLE_BITS'(a1), SAMPLE_BITS'(a0)};
	endfunction

	function automatic sample_vec_t flat(int v);
		return mk(v, v, v, v, v, v);
	endfunction

	function automatic sample_vec_t noise_scan();
		sample_vec_t s;
		for (int i = 0; i < CHANNELS; i++) begin
			case ($urandom_range(3))
				0: s[i] = '0;
				1: s[i] = SAMPLE_BITS'(SAMPLE_MAX);
				default: s[i] = SAMPLE_BITS'($urandom_range(SAMPLE_MAX));
			endcase
		end
		return s;
	endfunction

	function automatic sample_vec_t near_scan(int center, int spread);
		sample_vec_t s;
		int          v;
		for (int i = 0; i < CHANNELS; i++) begin
			v = center - spread + int'($urandom_range(2 * spread));
			if (v < 0) begin
				v = 0;
			end
			if (v > SAMPLE_MAX) begin
				v = SAMPLE_MAX;
			end
			s[i] = SAMPLE_BITS'(v);
		end
		return s;
	endfunction

	task automatic send_scan(snm_op_t op, sample_vec_t s);
		int gap;
		in_ch.valid   <= 1'b1;
		in_ch.opcode  <= op;
		in_ch.sample0 <= s[0];
		in_ch.sample1 <= s[1];
		in_ch.sample2 <= s[2];
		in_ch.sample3 <= s[3];
		in_ch.sample4 <= s[4];
		in_ch.sample5 <= s[5];
		do @(posedge clk); while (!in_ch.ready);
		if (op != OP_IGNORE) begin
			scans_sent++;
		end
		gap = 0;
		while (gap < 40 && $urandom_range(99) < send_idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// wait until every completed average has left, then let the lanes settle
	task automatic drain();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_config(logic [AVG_BITS-1:0] avg, logic [NORM_BITS-1:0] fs);
		cfg_we   <= 1'b1;
		cfg_idx  <= CFG_AVG_COUNT;
		cfg_data <= {8'($urandom_range(255)), avg};
		@(posedge clk);
		cfg_idx  <= CFG_FULL_SCALE;
		cfg_data <= fs;
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	// calibrate around a random level, then measure with an occasional broken beat
	task automatic run_sequence(int measures, int broken_pct);
		int center;
		int spread;
		int r;
		center = $urandom_range(SAMPLE_MAX);
		case ($urandom_range(4))
			0: spread = 0;
			1: spread = $urandom_range(1, 16);
			2: spread = $urandom_range(17, 600);
			default: spread = SAMPLE_MAX;
		endcase
		send_scan(OP_RESTART, near_scan(center, spread));
		repeat ($urandom_range(3)) send_scan(OP_UPDATE, near_scan(center, spread));
		repeat (measures) begin
			r = $urandom_range(99);
			if (r < broken_pct) begin
				case ($urandom_range(2))
					0: send_scan(OP_IGNORE, noise_scan());
					1: send_scan(OP_UPDATE, noise_scan());
					default: send_scan(snm_op_t'($urandom_range(3)), noise_scan());
				endcase
			end else begin
				send_scan(OP_MEASURE, near_scan(center, spread + spread / 4 + 2));
			end
		end
	endtask

	initial begin
		int hold_left;
		int holds_seen;
		hold_left    = 0;
		holds_seen   = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (holds_seen != hold_reqs) begin
				holds_seen = hold_reqs;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("FAIL sensor_minmax_normalizer");
				$finish;
			end
		end
	end

	initial begin
		int                   phase;
		int                   avg_eff;
		logic [AVG_BITS-1:0]  avg;
		logic [NORM_BITS-1:0] fs;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_idx        = CFG_AVG_COUNT;
		cfg_data       = '0;
		in_ch.valid    = 1'b0;
		in_ch.opcode   = OP_IGNORE;
		in_ch.sample0  = '0;
		in_ch.sample1  = '0;
		in_ch.sample2  = '0;
		in_ch.sample3  = '0;
		in_ch.sample4  = '0;
		in_ch.sample5  = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_reqs      = 0;
		scans_sent     = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, update with no prior restart keeps min at zero
		send_scan(OP_UPDATE, mk(4095, 0, 1234, 4095, 1, 2048));
		send_scan(OP_MEASURE, flat(4095));
		send_scan(OP_MEASURE, flat(0));
		send_scan(OP_IGNORE, flat(4095));
		send_scan(OP_MEASURE, mk(100, 200, 617, 3000, 1, 1024));
		send_scan(OP_MEASURE, noise_scan());
		// partial average discarded by calibration, then widened range
		send_scan(OP_RESTART, flat(2000));
		send_scan(OP_MEASURE, flat(2000));
		send_scan(OP_UPDATE, mk(0, 4095, 1500, 2500, 2000, 1990));
		send_scan(OP_UPDATE, mk(4095, 0, 1000, 3000, 2000, 2010));
		send_scan(OP_MEASURE, flat(4095));
		send_scan(OP_MEASURE, flat(0));
		send_scan(OP_MEASURE, mk(2000, 2000, 1200, 2600, 2000, 2005));
		send_scan(OP_MEASURE, noise_scan());
		drain();

		write_config(8'd1, 16'hFFFF);
		send_scan(OP_RESTART, flat(0));
		send_scan(OP_UPDATE, flat(4095));
		send_scan(OP_MEASURE, flat(4095));
		send_scan(OP_MEASURE, flat(0));
		drain();

		write_config(8'd0, 16'd0);
		send_scan(OP_MEASURE, noise_scan());
		drain();

		// average target lowered while scans are already summed
		write_config(8'd10, 16'd1);
		repeat (5) send_scan(OP_MEASURE, noise_scan());
		drain();
		write_config(8'd3, 16'd1000);
		send_scan(OP_MEASURE, noise_scan());
		drain();

		scans_sent = 0;
		phase      = 0;
		while (scans_sent < RANDOM_SCANS) begin
			if (phase == 3) begin
				avg = 8'd1;
			end else if (phase == 6) begin
				avg = 8'd255;
			end else begin
				case ($urandom_range(9))
					0: avg = 8'd0;
					1: avg = 8'd1;
					2: avg = 8'($urandom_range(9, 40));
					default: avg = 8'($urandom_range(1, 8));
				endcase
			end
			case ($urandom_range(5))
				0: fs = 16'hFFFF;
				1: fs = 16'd1;
				2: fs = 16'd0;
				3: fs = 16'd1000;
				default: fs = 16'($urandom_range(65535));
			endcase
			write_config(avg, fs);
			case (phase % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 60;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 60;
				end
				default: begin
					send_idle_pct  = 34;
					recv_stall_pct = 34;
				end
			endcase
			avg_eff = (avg == '0) ? 1 : int'(avg);
			if (phase == 3) begin
				// receiver holds off while full-rate measures pile up behind it
				send_idle_pct  = 0;
				recv_stall_pct = 0;
				hold_reqs++;
				repeat (40) send_scan(OP_MEASURE, noise_scan());
			end else if (avg == 8'd255) begin
				run_sequence(300, 0);
			end else begin
				repeat ($urandom_range(2, 5)) begin
					run_sequence(avg_eff * $urandom_range(1, 5) + $urandom_range(3), 8);
				end
			end
			drain();
			phase++;
		end

		if (mismatches == 0) begin
			$display("PASS sensor_minmax_normalizer");
		end else begin
			$display("FAIL sensor_minmax_normalizer");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/snm_pkg.sv
rtl/snm_in_if.sv
rtl/snm_out_if.sv
rtl/snm_div.sv
rtl/snm_lane.sv
rtl/sensor_minmax_normalizer.sv
tb/snm_result_checker.sv
tb/tb_sensor_minmax_normalizer.sv
